// ===== rtl/core/edge_flux_residual_defines.svh =====
// Assertion macros for the edge flux pipeline.
// Used by the top level; expects clk and arst_n in scope.
`ifndef EDGE_FLUX_RESIDUAL_DEFINES_SVH
`define EDGE_FLUX_RESIDUAL_DEFINES_SVH

// same-cycle implication
`define EFR_ASSERT_IMP(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("edge_flux_residual: check failed");

// next-cycle implication
`define EFR_ASSERT_NXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("edge_flux_residual: check failed");

`endif

// ===== rtl/core/efr_pkg.sv =====
// Shared types, constants and saturation helpers for the edge flux pipeline.
// No dependencies.
`default_nettype none

package efr_pkg;

	localparam int ACC_W   = 68;
	localparam int NUM_W   = 64;
	localparam int DEN_W   = 33;
	localparam int QUO_W   = 33;
	localparam int DIV_LAT = QUO_W + 1;

	localparam logic [7:0]  REG_GM1 = 8'd0;
	localparam logic [7:0]  REG_EPS = 8'd1;
	localparam logic [25:0] GM1_RESET = 26'd6710886;
	localparam logic [24:0] EPS_RESET = 25'd838861;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] v;
	} sat_t;

	localparam logic signed [ACC_W-1:0] S32_MAX_W = 68'sh7FFFFFFF;
	localparam logic signed [ACC_W-1:0] S32_MIN_W = -68'sh80000000;

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t r;
		r.sat = 1'b0;
		r.v   = v[31:0];
		if (v > S32_MAX_W) begin
			r.sat = 1'b1;
			r.v   = 32'sh7FFFFFFF;
		end else if (v < S32_MIN_W) begin
			r.sat = 1'b1;
			r.v   = 32'sh80000000;
		end
		return r;
	endfunction

	function automatic sat_t quot_sat(input logic [QUO_W-1:0] q, input logic ovf,
			input logic neg);
		sat_t r;
		r.sat = 1'b0;
		r.v   = neg ? 32'(32'd0 - q[31:0]) : q[31:0];
		if (neg && (ovf || q > 33'h080000000)) begin
			r.sat = 1'b1;
			r.v   = 32'sh80000000;
		end else if (!neg && (ovf || q > 33'h07FFFFFFF)) begin
			r.sat = 1'b1;
			r.v   = 32'sh7FFFFFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/edge_flux_residual.sv =====
// Channel  | group                    | payload
// s_       | tvalid tready tdata[383:0] | edge vector, two cells, timesteps
// m_       | tvalid tready tdata tuser | four fluxes, status
// cfg_     | valid ready index data    | gamma-1 (0), eps (1)
// One edge per cycle while the output is not stalled; stages: 2 + 34 divider stages + 6 + output.
// Four 33-step restoring dividers (kinetic term, normal velocity) set the depth.
// Reset clears valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Top level of the edge flux pipeline; depends on efr_pkg, efr_div and the defines header.
`default_nettype none
`include "edge_flux_residual_defines.svh"

module edge_flux_residual #(
	parameter int FRAC_BITS = 24
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// edge_dx, edge_dy, left_density, left_mom_x, left_mom_y, left_energy,
	// right_density, right_mom_x, right_mom_y, right_energy,
	// left_timestep (31), right_timestep (31), 2 pad bits
	input  wire  [383:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// flux_mass, flux_mom_x, flux_mom_y, flux_energy
	output logic [127:0] m_tdata,
	// status
	output logic [1:0]   m_tuser,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [7:0]   cfg_index,
	input  wire  [25:0]  cfg_data
);

	localparam int AW = efr_pkg::ACC_W;
	localparam int DL = efr_pkg::DIV_LAT;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic [1:0][31:0]   rho;
		logic [1:0][31:0]   mx;
		logic [1:0][31:0]   my;
		logic [1:0][31:0]   en;
		logic signed [31:0] mu;
		logic               zero;
		logic               sat;
	} item_t;

	function automatic logic signed [65:0] fxm(input logic signed [32:0] a,
			input logic signed [32:0] b);
		logic signed [65:0] pr;
		pr = a * b;
		return pr >>> FRAC_BITS;
	endfunction

	// configuration
	logic [25:0] gm1_q;
	logic [24:0] eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm1_q <= efr_pkg::GM1_RESET;
			eps_q <= efr_pkg::EPS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == efr_pkg::REG_GM1) begin
				gm1_q <= cfg_data;
			end else if (cfg_index == efr_pkg::REG_EPS) begin
				eps_q <= cfg_data[24:0];
			end
		end
	end

	logic en;
	logic m_tvalid_q;
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = m_tvalid_q;

	// input unpack
	logic signed [31:0] in_mx  [2];
	logic signed [31:0] in_my  [2];
	logic signed [31:0] in_dx, in_dy;
	item_t              in_it;

	assign in_dx     = $signed(s_tdata[31:0]);
	assign in_dy     = $signed(s_tdata[63:32]);
	assign in_mx[0]  = $signed(s_tdata[127:96]);
	assign in_my[0]  = $signed(s_tdata[159:128]);
	assign in_mx[1]  = $signed(s_tdata[255:224]);
	assign in_my[1]  = $signed(s_tdata[287:256]);

	always_comb begin
		in_it        = '0;
		in_it.dx     = in_dx;
		in_it.dy     = in_dy;
		in_it.rho[0] = s_tdata[95:64];
		in_it.mx[0]  = s_tdata[127:96];
		in_it.my[0]  = s_tdata[159:128];
		in_it.en[0]  = s_tdata[191:160];
		in_it.rho[1] = s_tdata[223:192];
		in_it.mx[1]  = s_tdata[255:224];
		in_it.my[1]  = s_tdata[287:256];
		in_it.en[1]  = s_tdata[319:288];
	end

	// stage 1: squares and cross products
	logic               vld_s1;
	item_t              it_s1;
	logic signed [63:0] pmx_s1 [2];
	logic signed [63:0] pmy_s1 [2];
	logic signed [63:0] pa_s1  [2];
	logic signed [63:0] pb_s1  [2];
	logic [31:0]        tsum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= in_it;
			tsum_s1 <= {1'b0, s_tdata[350:320]} + {1'b0, s_tdata[381:351]};
			for (int c = 0; c < 2; c++) begin
				pmx_s1[c] <= in_mx[c] * in_mx[c];
				pmy_s1[c] <= in_my[c] * in_my[c];
				pa_s1[c]  <= in_mx[c] * in_dy;
				pb_s1[c]  <= in_my[c] * in_dx;
			end
		end
	end

	// stage 2: divider operands, mu, zero density
	logic                vld_s2;
	item_t               it_s2;
	logic [63:0]         kn_s2 [2];
	logic [32:0]         kd_s2 [2];
	logic                kneg_s2 [2];
	logic [63:0]         vn_s2 [2];
	logic [32:0]         vd_s2 [2];
	logic                vneg_s2 [2];

	logic signed [64:0]  numv [2];
	logic [31:0]         magr [2];
	logic                rneg [2];
	logic [55:0]         mup;
	efr_pkg::sat_t       mus;
	item_t               it2_d;

	always_comb begin
		mup = tsum_s1[31:1] * eps_q;
		mus = efr_pkg::sat32($signed(AW'(mup >> FRAC_BITS)));
		for (int c = 0; c < 2; c++) begin
			rneg[c] = it_s1.rho[c][31];
			magr[c] = rneg[c] ? 32'(33'd0 - 33'($signed(it_s1.rho[c])))
			                  : it_s1.rho[c];
			numv[c] = 65'(pa_s1[c]) - 65'(pb_s1[c]);
		end
		it2_d      = it_s1;
		it2_d.mu   = mus.v;
		it2_d.sat  = mus.sat;
		it2_d.zero = (it_s1.rho[0] == '0) || (it_s1.rho[1] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it2_d;
			for (int c = 0; c < 2; c++) begin
				kn_s2[c]   <= $unsigned(pmx_s1[c]) + $unsigned(pmy_s1[c]);
				kd_s2[c]   <= {magr[c], 1'b0};
				kneg_s2[c] <= rneg[c];
				vn_s2[c]   <= numv[c][64] ? 64'(65'd0 - $unsigned(numv[c]))
				                          : numv[c][63:0];
				vd_s2[c]   <= {1'b0, magr[c]};
				vneg_s2[c] <= numv[c][64] ^ rneg[c];
			end
		end
	end

	// dividers and matching delay line
	logic [32:0] kq [2];
	logic        kovf [2];
	logic        kqneg [2];
	logic [32:0] vq [2];
	logic        vovf [2];
	logic        vqneg [2];

	for (genvar c = 0; c < 2; c++) begin : g_cell
		efr_div u_ke (
			.clk     (clk),
			.en      (en),
			.num     (kn_s2[c]),
			.den     (kd_s2[c]),
			.neg     (kneg_s2[c]),
			.quo     (kq[c]),
			.ovf     (kovf[c]),
			.quo_neg (kqneg[c])
		);
		efr_div u_vol (
			.clk     (clk),
			.en      (en),
			.num     (vn_s2[c]),
			.den     (vd_s2[c]),
			.neg     (vneg_s2[c]),
			.quo     (vq[c]),
			.ovf     (vovf[c]),
			.quo_neg (vqneg[c])
		);
	end

	logic  vld_d [DL];
	item_t it_d  [DL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) begin
				vld_d[i] <= 1'b0;
			end
		end else if (en) begin
			vld_d[0] <= vld_s2;
			for (int i = 1; i < DL; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_d[0] <= it_s2;
			for (int i = 1; i < DL; i++) begin
				it_d[i] <= it_d[i-1];
			end
		end
	end

	// stage 3: quotient saturation
	logic               vld_s3;
	item_t              it_s3;
	logic signed [31:0] ke_s3  [2];
	logic signed [31:0] vol_s3 [2];
	efr_pkg::sat_t      kes [2];
	efr_pkg::sat_t      vs  [2];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			kes[c] = efr_pkg::quot_sat(kq[c], kovf[c], kqneg[c]);
			vs[c]  = efr_pkg::quot_sat(vq[c], vovf[c], vqneg[c]);
		end
	end

	// stage 4: energy minus kinetic term
	logic               vld_s4;
	item_t              it_s4;
	logic signed [31:0] inner_s4 [2];
	logic signed [31:0] vol_s4   [2];
	efr_pkg::sat_t      ins [2];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			ins[c] = efr_pkg::sat32(AW'($signed(it_s3.en[c])) - AW'(ke_s3[c]));
		end
	end

	// stage 5: pressure
	logic               vld_s5;
	item_t              it_s5;
	logic signed [31:0] p_s5   [2];
	logic signed [31:0] vol_s5 [2];
	logic signed [58:0] gp  [2];
	efr_pkg::sat_t      ps  [2];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			gp[c] = $signed({1'b0, gm1_q}) * inner_s4[c];
			ps[c] = efr_pkg::sat32(AW'(gp[c] >>> FRAC_BITS));
		end
	end

	// stage 6: energy plus pressure
	logic               vld_s6;
	item_t              it_s6;
	logic signed [31:0] h_s6   [2];
	logic signed [31:0] p_s6   [2];
	logic signed [31:0] vol_s6 [2];
	efr_pkg::sat_t      hs [2];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			hs[c] = efr_pkg::sat32(AW'($signed(it_s5.en[c])) + AW'(p_s5[c]));
		end
	end

	item_t it3_d, it4_d, it5_d, it6_d;

	always_comb begin
		it3_d     = it_d[DL-1];
		it3_d.sat = it_d[DL-1].sat | kes[0].sat | kes[1].sat | vs[0].sat | vs[1].sat;
		it4_d     = it_s3;
		it4_d.sat = it_s3.sat | ins[0].sat | ins[1].sat;
		it5_d     = it_s4;
		it5_d.sat = it_s4.sat | ps[0].sat | ps[1].sat;
		it6_d     = it_s5;
		it6_d.sat = it_s5.sat | hs[0].sat | hs[1].sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_d[DL-1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3 <= it3_d;
			it_s4 <= it4_d;
			it_s5 <= it5_d;
			it_s6 <= it6_d;
			for (int c = 0; c < 2; c++) begin
				ke_s3[c]    <= kes[c].v;
				vol_s3[c]   <= vs[c].v;
				inner_s4[c] <= ins[c].v;
				vol_s4[c]   <= vol_s3[c];
				p_s5[c]     <= ps[c].v;
				vol_s5[c]   <= vol_s4[c];
				h_s6[c]     <= hs[c].v;
				p_s6[c]     <= p_s5[c];
				vol_s6[c]   <= vol_s5[c];
			end
		end
	end

	// stage 7: flux products
	logic               vld_s7;
	logic               zero_s7;
	logic               sat_s7;
	logic signed [65:0] t_s7 [4][4];
	logic signed [65:0] d_s7 [4];
	logic signed [32:0] v0, v1, pp0, pp1, hh0, hh1, mu6, dx6, dy6;

	always_comb begin
		v0  = 33'(vol_s6[0]);
		v1  = 33'(vol_s6[1]);
		pp0 = 33'(p_s6[0]);
		pp1 = 33'(p_s6[1]);
		hh0 = 33'(h_s6[0]);
		hh1 = 33'(h_s6[1]);
		mu6 = 33'(it_s6.mu);
		dx6 = 33'(it_s6.dx);
		dy6 = 33'(it_s6.dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s7    <= it_s6.zero;
			sat_s7     <= it_s6.sat;
			t_s7[0][0] <= fxm(v0, 33'($signed(it_s6.rho[0])));
			t_s7[0][1] <= fxm(v1, 33'($signed(it_s6.rho[1])));
			t_s7[0][2] <= '0;
			t_s7[0][3] <= '0;
			t_s7[1][0] <= fxm(v0, 33'($signed(it_s6.mx[0])));
			t_s7[1][1] <= fxm(pp0, dy6);
			t_s7[1][2] <= fxm(v1, 33'($signed(it_s6.mx[1])));
			t_s7[1][3] <= fxm(pp1, dy6);
			t_s7[2][0] <= fxm(v0, 33'($signed(it_s6.my[0])));
			t_s7[2][1] <= -fxm(pp0, dx6);
			t_s7[2][2] <= fxm(v1, 33'($signed(it_s6.my[1])));
			t_s7[2][3] <= -fxm(pp1, dx6);
			t_s7[3][0] <= fxm(v0, hh0);
			t_s7[3][1] <= fxm(v1, hh1);
			t_s7[3][2] <= '0;
			t_s7[3][3] <= '0;
			d_s7[0] <= fxm(mu6, 33'($signed(it_s6.rho[0])) - 33'($signed(it_s6.rho[1])));
			d_s7[1] <= fxm(mu6, 33'($signed(it_s6.mx[0])) - 33'($signed(it_s6.mx[1])));
			d_s7[2] <= fxm(mu6, 33'($signed(it_s6.my[0])) - 33'($signed(it_s6.my[1])));
			d_s7[3] <= fxm(mu6, 33'($signed(it_s6.en[0])) - 33'($signed(it_s6.en[1])));
		end
	end

	// stage 8: central average plus dissipation
	logic                vld_s8;
	logic                zero_s8;
	logic                sat_s8;
	logic signed [AW-1:0] f_s8 [4];
	logic signed [AW-1:0] csum [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			csum[k] = AW'(t_s7[k][0]) + AW'(t_s7[k][1]) + AW'(t_s7[k][2]) + AW'(t_s7[k][3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s8 <= zero_s7;
			sat_s8  <= sat_s7;
			for (int k = 0; k < 4; k++) begin
				f_s8[k] <= (csum[k] >>> 1) + AW'(d_s7[k]);
			end
		end
	end

	// output register
	efr_pkg::sat_t    fs [4];
	logic             any_sat;
	logic [127:0]     out_data;
	efr_pkg::status_t out_st;
	logic [127:0]     m_tdata_q;
	logic [1:0]       m_tuser_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			fs[k] = efr_pkg::sat32(f_s8[k]);
		end
		any_sat  = sat_s8 | fs[0].sat | fs[1].sat | fs[2].sat | fs[3].sat;
		out_data = {fs[3].v, fs[2].v, fs[1].v, fs[0].v};
		out_st   = any_sat ? efr_pkg::ST_SAT : efr_pkg::ST_OK;
		if (zero_s8) begin
			out_data = '0;
			out_st   = efr_pkg::ST_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= out_data;
			m_tuser_q <= out_st;
		end
	end

	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	`EFR_ASSERT_IMP(a_zero_clears, m_tvalid && m_tuser == efr_pkg::ST_ZERO, m_tdata == '0)
	`EFR_ASSERT_NXT(a_ingress, s_tvalid && s_tready, vld_s1)
	`EFR_ASSERT_NXT(a_stall_holds, !en, $stable(vld_d[0]))

endmodule

`default_nettype wire

// ===== rtl/core/efr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// Depends on efr_pkg.
`default_nettype none

module efr_div (
	input  wire                          clk,
	input  wire                          en,
	input  wire  [efr_pkg::NUM_W-1:0]    num,
	input  wire  [efr_pkg::DEN_W-1:0]    den,
	input  wire                          neg,
	output logic [efr_pkg::QUO_W-1:0]    quo,
	output logic                         ovf,
	output logic                         quo_neg
);

	localparam int QW = efr_pkg::QUO_W;
	localparam int CW = efr_pkg::NUM_W + 2;

	logic [efr_pkg::NUM_W-1:0] rem_s [QW];
	logic [efr_pkg::DEN_W-1:0] den_s [QW];
	logic [QW-1:0]             quo_s [QW+1];
	logic                      ovf_s [QW+1];
	logic                      neg_s [QW+1];

	logic [CW-1:0]             diff  [1:QW];
	logic [efr_pkg::NUM_W-1:0] rem_d [1:QW];
	logic [QW-1:0]             quo_d [1:QW];

	always_comb begin
		for (int k = 1; k <= QW; k++) begin
			diff[k]  = {2'b00, rem_s[k-1]} - (CW'(den_s[k-1]) << (QW - k));
			rem_d[k] = rem_s[k-1];
			quo_d[k] = quo_s[k-1];
			if (!diff[k][CW-1]) begin
				rem_d[k]        = diff[k][efr_pkg::NUM_W-1:0];
				quo_d[k][QW-k]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= {2'b00, num[efr_pkg::NUM_W-1:QW]} >= den;
			neg_s[0] <= neg;
			for (int k = 1; k < QW; k++) begin
				rem_s[k] <= rem_d[k];
				den_s[k] <= den_s[k-1];
			end
			for (int k = 1; k <= QW; k++) begin
				quo_s[k] <= quo_d[k];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign quo     = quo_s[QW];
	assign ovf     = ovf_s[QW];
	assign quo_neg = neg_s[QW];

endmodule

`default_nettype wire
